[src/xcfr_pkg.sv]
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants of the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

    // Configuration register widths and reset values
    localparam int unsigned MAX_LEN_W  = 17;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 17'd4096;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [CODE_W-1:0]    ACK_RESET     = 8'd0;
    localparam logic [CODE_W-1:0]    NACK_RESET    = 8'd1;

    // Header overhead added to the declared length before the size check
    localparam logic [MAX_LEN_W-1:0] FRAME_OVERHEAD = 17'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_LENGTH    = 2'd0,
        CFG_TIMEOUT_TICKS = 2'd1,
        CFG_ACK_CODE      = 2'd2,
        CFG_NACK_CODE     = 2'd3
    } cfg_index_t;

    // Receive phase
    typedef enum logic [2:0] {
        PH_TYPE = 3'd0,
        PH_LENH = 3'd1,
        PH_LENL = 3'd2,
        PH_DATA = 3'd3,
        PH_CSUM = 3'd4
    } phase_t;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result kinds
    localparam logic [1:0] OK_PAYLOAD = 2'd0;
    localparam logic [1:0] OK_STATUS  = 2'd1;
    localparam logic [1:0] OK_REPLY   = 2'd2;

    // Frame status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADSUM  = 2'd1;
    localparam logic [1:0] ST_TOOLONG = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // Checksum burst: one status beat then four reply beats
    localparam logic [2:0] BURST_LAST = 3'd4;

    // Result group produced by the parser for one input item
    typedef struct packed {
        logic        valid;    // item produced at least one result
        logic        burst;    // checksum burst of five beats
        logic [1:0]  kind;     // kind of a single-beat result
        logic [7:0]  value;    // payload byte, or reply code for a burst
        logic [1:0]  status;
        logic [7:0]  ftype;
        logic [15:0] flength;
    } result_t;

endpackage

[src/xor_checked_frame_receiver.sv]
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Type-length-value frame receiver with XOR checksum and ACK/NACK reply.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one beat is a received byte (kind 0)
// or a timekeeping tick (kind 1). Output channel (out_valid/out_stall):
// payload bytes, frame status and reply bytes, with last on the final beat
// caused by an input beat.
// Each result is registered and appears on the output in the cycle after its input beat.
// Throughput: one input beat per cycle while each beat yields at most one
// result and out_stall is low. A checksum byte yields five output beats
// (status, then the four-byte reply), and input is held off until the
// final reply beat is taken; the single output register causes this.
// Header bytes and ticks that make no result still take an input beat.
// Stall: out_stall holds the current beat; in_stall rises whenever the
// output register is occupied and its final beat is not taken this cycle.
// Reset: registers return to max_length 4096, timeout_ticks 1000, ACK code 0,
// NACK code 1; the receiver waits for a type byte and the output is empty.
// Configuration writes via cfg_we/cfg_index/cfg_data are registered before use.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [xcfr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [7:0]                         rx_byte,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         out_kind,
    output logic [7:0]                         value,
    output logic [1:0]                         status,
    output logic [7:0]                         frame_type,
    output logic [15:0]                        frame_length,
    output logic                               last
);

    logic [xcfr_pkg::MAX_LEN_W-1:0] max_length_reg;
    logic [xcfr_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [xcfr_pkg::CODE_W-1:0]    ack_reg;
    logic [xcfr_pkg::CODE_W-1:0]    nack_reg;

    xcfr_pkg::result_t result;
    xcfr_pkg::result_t out_reg;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        beat_reg, beat_next;

    logic in_take;
    logic out_take;
    logic out_done;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= xcfr_pkg::MAX_LEN_RESET;
            timeout_reg    <= xcfr_pkg::TIMEOUT_RESET;
            ack_reg        <= xcfr_pkg::ACK_RESET;
            nack_reg       <= xcfr_pkg::NACK_RESET;
        end
        else if (cfg_we)
        begin
            case (xcfr_pkg::cfg_index_t'(cfg_index))
                xcfr_pkg::CFG_MAX_LENGTH:    max_length_reg <= cfg_data;
                xcfr_pkg::CFG_TIMEOUT_TICKS: timeout_reg    <= cfg_data[xcfr_pkg::TIMEOUT_W-1:0];
                xcfr_pkg::CFG_ACK_CODE:      ack_reg        <= cfg_data[xcfr_pkg::CODE_W-1:0];
                xcfr_pkg::CFG_NACK_CODE:     nack_reg       <= cfg_data[xcfr_pkg::CODE_W-1:0];
                default:                     ack_reg        <= ack_reg;
            endcase
        end
    end

    // Handshakes
    assign out_take = out_valid_reg && !out_stall;
    assign out_done = out_take && last;
    assign in_stall = out_valid_reg && !out_done;
    assign in_take  = in_valid && !in_stall;

    xcfr_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_take),
        .kind          (kind),
        .rx_byte       (rx_byte),
        .max_length    (max_length_reg),
        .timeout_ticks (timeout_reg),
        .ack_code      (ack_reg),
        .nack_code     (nack_reg),
        .result        (result)
    );

    // Output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        beat_next      = beat_reg;
        if (in_take)
        begin
            out_valid_next = result.valid;
            beat_next      = 3'd0;
        end
        else if (out_take)
        begin
            if (last)
            begin
                out_valid_next = 1'b0;
            end
            else
            begin
                beat_next = beat_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            beat_reg      <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            beat_reg      <= beat_next;
        end
    end

    // Output payload, loaded on accept
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            out_reg <= result;
        end
    end

    // Beat decode: a checksum burst is status, reply code, then three zeros
    always_comb
    begin
        out_kind = out_reg.kind;
        value    = out_reg.value;
        last     = 1'b1;
        if (out_reg.burst)
        begin
            last = (beat_reg == xcfr_pkg::BURST_LAST);
            case (beat_reg)
                3'd0:
                begin
                    out_kind = xcfr_pkg::OK_STATUS;
                    value    = 8'd0;
                end
                3'd1:
                begin
                    out_kind = xcfr_pkg::OK_REPLY;
                    value    = out_reg.value;
                end
                default:
                begin
                    out_kind = xcfr_pkg::OK_REPLY;
                    value    = 8'd0;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign frame_type   = out_reg.ftype;
    assign frame_length = out_reg.flength;

    // Burst counter stays inside the five beats
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.burst |-> beat_reg <= xcfr_pkg::BURST_LAST)
    else $error("burst beat counter overran");

    // A taken beat that is not last is followed by another beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
    else $error("result group cut short");

    // A new item never overwrites a beat that is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid || (!out_stall && last))
    else $error("input accepted over a pending result");

    // A burst always opens with its status beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && out_reg.burst |-> out_kind == xcfr_pkg::OK_STATUS)
    else $error("checksum burst did not open with status");

endmodule

[src/xcfr_parser.sv]
// ----------------------------------------------------------------------------
// xcfr_parser
// Frame state machine: tracks header, data, checksum and tick timeout, and
// forms the result group for each accepted item.
// ----------------------------------------------------------------------------
module xcfr_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              kind,
    input  logic [7:0]                        rx_byte,
    input  logic [xcfr_pkg::MAX_LEN_W-1:0]    max_length,
    input  logic [xcfr_pkg::TIMEOUT_W-1:0]    timeout_ticks,
    input  logic [xcfr_pkg::CODE_W-1:0]       ack_code,
    input  logic [xcfr_pkg::CODE_W-1:0]       nack_code,
    output xcfr_pkg::result_t                 result
);

    xcfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  held_type_reg, held_type_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] ticks_reg, ticks_next;

    logic [15:0] len_low;
    logic        too_long;
    logic [15:0] seen_inc;
    logic        tick_expired;
    logic        sum_ok;

    // Shared decode
    assign len_low      = {length_reg[15:8], rx_byte};
    assign too_long     = ({1'b0, len_low} + xcfr_pkg::FRAME_OVERHEAD) > max_length;
    assign seen_inc     = seen_reg + 16'd1;
    assign tick_expired = (ticks_reg <= 16'd1);
    assign sum_ok       = (rx_byte == xor_reg);

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        held_type_next = held_type_reg;
        length_next    = length_reg;
        seen_next      = seen_reg;
        xor_next       = xor_reg;
        ticks_next     = ticks_reg;
        if (kind == xcfr_pkg::KIND_TICK)
        begin
            if (phase_reg == xcfr_pkg::PH_DATA || phase_reg == xcfr_pkg::PH_CSUM)
            begin
                if (tick_expired)
                begin
                    ticks_next = 16'd0;
                    phase_next = xcfr_pkg::PH_TYPE;
                end
                else
                begin
                    ticks_next = ticks_reg - 16'd1;
                end
            end
        end
        else
        begin
            case (phase_reg)
                xcfr_pkg::PH_TYPE:
                begin
                    held_type_next = rx_byte;
                    length_next    = 16'd0;
                    phase_next     = xcfr_pkg::PH_LENH;
                end
                xcfr_pkg::PH_LENH:
                begin
                    length_next = {rx_byte, 8'd0};
                    phase_next  = xcfr_pkg::PH_LENL;
                end
                xcfr_pkg::PH_LENL:
                begin
                    length_next = len_low;
                    if (too_long)
                    begin
                        phase_next = xcfr_pkg::PH_TYPE;
                    end
                    else
                    begin
                        ticks_next = timeout_ticks;
                        seen_next  = 16'd0;
                        xor_next   = 8'd0;
                        phase_next = (len_low == 16'd0) ? xcfr_pkg::PH_CSUM
                                                        : xcfr_pkg::PH_DATA;
                    end
                end
                xcfr_pkg::PH_DATA:
                begin
                    xor_next  = xor_reg ^ rx_byte;
                    seen_next = seen_inc;
                    if (seen_inc >= length_reg)
                    begin
                        phase_next = xcfr_pkg::PH_CSUM;
                    end
                end
                xcfr_pkg::PH_CSUM:
                begin
                    phase_next = xcfr_pkg::PH_TYPE;
                end
                default:
                begin
                    phase_next = xcfr_pkg::PH_TYPE;
                end
            endcase
        end
    end

    // Result group; type and length as they stand after this item
    always_comb
    begin
        result         = '0;
        result.ftype   = held_type_next;
        result.flength = length_next;
        if (kind == xcfr_pkg::KIND_TICK)
        begin
            if ((phase_reg == xcfr_pkg::PH_DATA || phase_reg == xcfr_pkg::PH_CSUM)
                && tick_expired)
            begin
                result.valid  = 1'b1;
                result.kind   = xcfr_pkg::OK_STATUS;
                result.status = xcfr_pkg::ST_TIMEOUT;
            end
        end
        else
        begin
            case (phase_reg)
                xcfr_pkg::PH_LENL:
                begin
                    if (too_long)
                    begin
                        result.valid  = 1'b1;
                        result.kind   = xcfr_pkg::OK_STATUS;
                        result.status = xcfr_pkg::ST_TOOLONG;
                    end
                end
                xcfr_pkg::PH_DATA:
                begin
                    result.valid = 1'b1;
                    result.kind  = xcfr_pkg::OK_PAYLOAD;
                    result.value = rx_byte;
                end
                xcfr_pkg::PH_CSUM:
                begin
                    result.valid  = 1'b1;
                    result.burst  = 1'b1;
                    result.kind   = xcfr_pkg::OK_STATUS;
                    result.value  = sum_ok ? ack_code : nack_code;
                    result.status = sum_ok ? xcfr_pkg::ST_OK : xcfr_pkg::ST_BADSUM;
                end
                default:
                begin
                    result.valid = 1'b0;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= xcfr_pkg::PH_TYPE;
            held_type_reg <= 8'd0;
            length_reg    <= 16'd0;
            seen_reg      <= 16'd0;
            xor_reg       <= 8'd0;
            ticks_reg     <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            held_type_reg <= held_type_next;
            length_reg    <= length_next;
            seen_reg      <= seen_next;
            xor_reg       <= xor_next;
            ticks_reg     <= ticks_next;
        end
    end

    // In the data phase at least one data byte is still due
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == xcfr_pkg::PH_DATA |-> seen_reg < length_reg)
    else $error("data phase with no data byte outstanding");

endmodule
